// ----- sv/rcd_pkg.sv -----
`default_nettype none

package rcd_pkg;

    localparam int WINDOW_LENGTH_DEF = 20;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam int DISTANCE_BITS = 16;
    localparam int CFG_DATA_BITS = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int HOLDOFF_BITS  = 9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLDOFF   = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] TOLERANCE_RESET = 8'd2;
    localparam logic [CFG_DATA_BITS-1:0] HOLDOFF_RESET   = 8'd40;

    // Control flags of the window stage, handed to the evaluation stage.
    typedef struct packed {
        logic valid;
        logic full;
    } stage_t;

    typedef struct packed {
        logic                      write_en;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_write_t;

endpackage

`default_nettype wire

// ----- sv/rcd_window.sv -----
`default_nettype none

module rcd_window #(
    parameter int WINDOW_LENGTH = rcd_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = rcd_pkg::SAMPLE_BITS_DEF,
    localparam int HALF_LEN  = WINDOW_LENGTH / 2,
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(HALF_LEN + 1),
    localparam int FILL_BITS = $clog2(WINDOW_LENGTH + 1)
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          sample_valid,
    output logic                         sample_ready,
    input  wire  [SAMPLE_BITS-1:0]       sample,
    input  wire                          stage_take,
    output rcd_pkg::stage_t              stage,
    output logic [SUM_BITS-1:0]          older_sum,
    output logic [SUM_BITS-1:0]          newer_sum
);

    logic [SAMPLE_BITS-1:0] window_reg  [WINDOW_LENGTH];
    logic [SAMPLE_BITS-1:0] window_next [WINDOW_LENGTH];
    logic [FILL_BITS-1:0]   fill_cnt_reg;
    logic [FILL_BITS-1:0]   fill_cnt_next;
    logic [SUM_BITS-1:0]    older_reg;
    logic [SUM_BITS-1:0]    older_next;
    logic [SUM_BITS-1:0]    newer_reg;
    logic [SUM_BITS-1:0]    newer_next;
    logic [SAMPLE_BITS-1:0] newer_in;
    rcd_pkg::stage_t        stage_reg;
    rcd_pkg::stage_t        stage_next;
    logic                   accept;
    logic                   filling;

    assign sample_ready = !stage_reg.valid || stage_take;
    assign accept       = sample_valid && sample_ready;
    assign filling      = fill_cnt_reg < FILL_BITS'(WINDOW_LENGTH);

    // Sample that enters the newer half on a shift.
    generate
        if (WINDOW_LENGTH % 2 == 1) begin : g_odd
            assign newer_in = window_reg[2 * HALF_LEN];
        end else begin : g_even
            assign newer_in = sample;
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < WINDOW_LENGTH; k++)
        begin
            if (filling)
            begin
                window_next[k] = (fill_cnt_reg == FILL_BITS'(k)) ? sample : window_reg[k];
            end
            else if (k == WINDOW_LENGTH - 1)
            begin
                window_next[k] = sample;
            end
            else
            begin
                window_next[k] = window_reg[(k + 1) % WINDOW_LENGTH];
            end
        end
    end

    always_comb
    begin
        older_next    = older_reg;
        newer_next    = newer_reg;
        fill_cnt_next = fill_cnt_reg;
        if (filling)
        begin
            fill_cnt_next = fill_cnt_reg + FILL_BITS'(1);
            if (fill_cnt_reg < FILL_BITS'(HALF_LEN))
            begin
                older_next = older_reg + SUM_BITS'(sample);
            end
            else if (fill_cnt_reg < FILL_BITS'(2 * HALF_LEN))
            begin
                newer_next = newer_reg + SUM_BITS'(sample);
            end
        end
        else
        begin
            // running sums follow the shift
            older_next = older_reg - SUM_BITS'(window_reg[0]) + SUM_BITS'(window_reg[HALF_LEN]);
            newer_next = newer_reg - SUM_BITS'(window_reg[HALF_LEN]) + SUM_BITS'(newer_in);
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid = 1'b1;
            stage_next.full  = (fill_cnt_next == FILL_BITS'(WINDOW_LENGTH));
        end
        else if (stage_take)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < WINDOW_LENGTH; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            older_reg    <= '0;
            newer_reg    <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            if (accept)
            begin
                fill_cnt_reg <= fill_cnt_next;
                older_reg    <= older_next;
                newer_reg    <= newer_next;
            end
        end
    end

    assign stage     = stage_reg;
    assign older_sum = older_reg;
    assign newer_sum = newer_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= FILL_BITS'(WINDOW_LENGTH))
        else $error("fill count past window length");

    a_full_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.valid && stage_reg.full |-> fill_cnt_reg == FILL_BITS'(WINDOW_LENGTH))
        else $error("full flag without a full window");

    a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.valid && !stage_take |-> !accept)
        else $error("item accepted over a held stage");

endmodule

`default_nettype wire

// ----- sv/rcd_eval.sv -----
`default_nettype none

module rcd_eval #(
    parameter int SUM_BITS = 20,
    localparam int PROD_BITS = SUM_BITS + rcd_pkg::CFG_DATA_BITS
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  rcd_pkg::cfg_write_t  cfg,
    input  rcd_pkg::stage_t      stage,
    input  wire  [SUM_BITS-1:0]  older_sum,
    input  wire  [SUM_BITS-1:0]  newer_sum,
    output logic                 stage_take,
    output logic                 result_valid,
    input  wire                  result_ready,
    output logic                 toggle_direction,
    output logic                 evaluated,
    output logic                 window_full
);

    localparam int HB = rcd_pkg::HOLDOFF_BITS;

    logic [rcd_pkg::CFG_DATA_BITS-1:0] tolerance_reg;
    logic [rcd_pkg::CFG_DATA_BITS-1:0] holdoff_period_reg;
    logic [HB-1:0]        holdoff_count_reg;
    logic [HB-1:0]        holdoff_count_next;
    logic                 result_valid_reg;
    logic                 toggle_reg;
    logic                 toggle_next;
    logic                 evaluated_reg;
    logic                 evaluated_next;
    logic                 full_reg;
    logic [PROD_BITS-1:0] tol_older;
    logic [PROD_BITS-1:0] tol_newer;
    logic                 ratio_hit;
    logic                 held;

    assign stage_take = stage.valid && (!result_valid_reg || result_ready);

    assign tol_older = PROD_BITS'(tolerance_reg) * PROD_BITS'(older_sum);
    assign tol_newer = PROD_BITS'(tolerance_reg) * PROD_BITS'(newer_sum);
    assign ratio_hit = (PROD_BITS'(newer_sum) >= tol_older) ||
                       (tol_newer <= PROD_BITS'(older_sum));

    assign held = (holdoff_count_reg != '0) &&
                  (holdoff_count_reg <= HB'(holdoff_period_reg));

    always_comb
    begin
        holdoff_count_next = holdoff_count_reg;
        toggle_next        = 1'b0;
        evaluated_next     = 1'b0;
        if (stage.full)
        begin
            if (held)
            begin
                holdoff_count_next = holdoff_count_reg + HB'(1);
            end
            else
            begin
                evaluated_next     = 1'b1;
                toggle_next        = ratio_hit;
                holdoff_count_next = ratio_hit ? HB'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg      <= rcd_pkg::TOLERANCE_RESET;
            holdoff_period_reg <= rcd_pkg::HOLDOFF_RESET;
        end
        else if (cfg.write_en)
        begin
            unique case (cfg.index)
                rcd_pkg::REG_TOLERANCE: tolerance_reg      <= cfg.data;
                rcd_pkg::REG_HOLDOFF:   holdoff_period_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_count_reg <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (stage_take)
            begin
                holdoff_count_reg <= holdoff_count_next;
                result_valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            toggle_reg    <= toggle_next;
            evaluated_reg <= evaluated_next;
            full_reg      <= stage.full;
        end
    end

    assign result_valid     = result_valid_reg;
    assign toggle_direction = toggle_reg;
    assign evaluated        = evaluated_reg;
    assign window_full      = full_reg;

    a_toggle_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && toggle_reg |-> evaluated_reg)
        else $error("toggle without evaluation");

    a_eval_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && evaluated_reg |-> full_reg)
        else $error("evaluation before window full");

    a_holdoff_starts: assert property (@(posedge clk) disable iff (!rst_n)
        stage_take && toggle_next |=> holdoff_count_reg == HB'(1))
        else $error("holdoff not started after toggle");

endmodule

`default_nettype wire

// ----- sv/range_change_direction_detector.sv -----
`default_nettype none

// Range change direction detector. Each distance sample item enters a window of
// WINDOW_LENGTH samples (fill first, then shift); once the window is full the sum
// of the older half is compared with the sum of the newer half, and a toggle is
// raised when newer >= tolerance*older or tolerance*newer <= older, after which
// holdoff_period items skip the compare. Registers: index 0 tolerance (reset 2),
// index 1 holdoff_period (reset 40); other indexes are ignored. Write them only
// while no item is in flight. One item can be taken every cycle while the result
// side keeps up. An accepted item is registered in the window stage, which keeps
// running half sums; the evaluation stage (tolerance multipliers and holdoff
// counter) then takes it, stalled while an untaken result is held, and loads the
// result register, from which the result is taken on result_ready.

module range_change_direction_detector #(
    parameter int WINDOW_LENGTH = rcd_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = rcd_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write_en,
    input  wire  [rcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [rcd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                 sample_valid,
    output logic                                sample_ready,
    input  wire  [rcd_pkg::DISTANCE_BITS-1:0]   distance_sample,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output logic                                toggle_direction,
    output logic                                evaluated,
    output logic                                window_full
);

    localparam int HALF_LEN = WINDOW_LENGTH / 2;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(HALF_LEN + 1);

    logic [SAMPLE_BITS-1:0] sample;
    logic [SUM_BITS-1:0]    older_sum;
    logic [SUM_BITS-1:0]    newer_sum;
    logic                   stage_take;
    rcd_pkg::stage_t        stage;
    rcd_pkg::cfg_write_t    cfg;

    generate
        if (SAMPLE_BITS <= rcd_pkg::DISTANCE_BITS) begin : g_trunc
            assign sample = distance_sample[SAMPLE_BITS-1:0];
        end else begin : g_ext
            assign sample = {{(SAMPLE_BITS - rcd_pkg::DISTANCE_BITS){1'b0}}, distance_sample};
        end
    endgenerate

    assign cfg.write_en = cfg_write_en;
    assign cfg.index    = cfg_index;
    assign cfg.data     = cfg_data;

    rcd_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .stage_take   (stage_take),
        .stage        (stage),
        .older_sum    (older_sum),
        .newer_sum    (newer_sum)
    );

    rcd_eval #(
        .SUM_BITS (SUM_BITS)
    ) u_eval (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .stage            (stage),
        .older_sum        (older_sum),
        .newer_sum        (newer_sum),
        .stage_take       (stage_take),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .toggle_direction (toggle_direction),
        .evaluated        (evaluated),
        .window_full      (window_full)
    );

endmodule

`default_nettype wire
